>>> rtl/hkl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hkl_pkg
// Shared types and codes for the held key list and its chain of slot cells.
// ----------------------------------------------------------------------------
package hkl_pkg;

	localparam logic [1:0] CMD_SCAN   = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] ST_ADDED    = 3'd0;
	localparam logic [2:0] ST_HELD     = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_RELEASED = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;
	localparam logic [2:0] ST_IGNORED  = 3'd5;
	localparam logic [2:0] ST_READ     = 3'd6;
	localparam logic [2:0] ST_CLEARED  = 3'd7;

	localparam logic [7:0] RELEASE_BIT = 8'h80;
	localparam logic [7:0] CODE_MASK   = 8'h7F;
	localparam logic [7:0] ZERO_BYTE   = 8'h00;

	typedef enum logic [1:0] {
		OP_PROBE,
		OP_RELEASE,
		OP_READ
	} op_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_WALK
	} fsm_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] scan_byte;
		logic [3:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] held_count;
		logic [6:0] slot_key;
		logic       slot_valid;
	} rsp_t;

	typedef struct packed {
		logic       active;
		op_t        op;
		logic [6:0] code;
		logic [3:0] idx;
		logic       found;
		logic [6:0] rkey;
	} tok_t;

endpackage
`default_nettype wire

>>> rtl/hkl_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hkl_cell
// One list slot. Each token is registered as it passes; the cell matches it,
// serves reads, takes an added key and pulls its neighbor's key on a release.
// ----------------------------------------------------------------------------
module hkl_cell
	import hkl_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tok_t          tok_in,
	output tok_t               tok_out,
	input  wire logic [CW-1:0] total,
	input  wire logic [6:0]    next_key,
	input  wire logic          wr_en,
	input  wire logic [CW-1:0] wr_idx,
	input  wire logic [6:0]    wr_key,
	output logic [6:0]         key
);

	logic [6:0] key_q;
	logic       act_q;
	tok_t       pay_q;
	tok_t       tok_nxt;
	logic       here;
	logic       hit;

	assign here = CW'(IDX) < total;
	assign hit  = tok_in.active && here && (key_q == tok_in.code) &&
	              (tok_in.op != OP_READ) && !tok_in.found;

	always_comb begin
		tok_nxt       = tok_in;
		tok_nxt.found = tok_in.found | hit;
		if (tok_in.op == OP_READ && here && 32'(tok_in.idx) == IDX) begin
			tok_nxt.rkey = key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= tok_in.active;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= tok_nxt;
		if (tok_in.active && tok_in.op == OP_RELEASE && tok_nxt.found) begin
			key_q <= next_key;
		end else if (wr_en && wr_idx == CW'(IDX)) begin
			key_q <= wr_key;
		end
	end

	always_comb begin
		tok_out        = pay_q;
		tok_out.active = act_q;
	end

	assign key = key_q;

endmodule
`default_nettype wire

>>> rtl/held_key_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// held_key_list
// Ordered list of held key codes built as a chain of slot cells.
// ----------------------------------------------------------------------------
// A request (req: cmd, scan_byte, slot_index) is taken on a rising edge with
// start high and busy low. Every request gives one result on rsp, marked by
// done for exactly one cycle; the receiver cannot stall it.
// Clear, zero-byte and unused commands answer on the next cycle, and busy
// stays low for them. Scancode and read requests send a token down the chain of
// LIST_DEPTH cells, registered in each cell in turn, for search, slot read and
// release shift; done and rsp are registered when the token leaves the chain,
// and busy holds off new requests until then.
// An add writes the new key into the first free cell when the token leaves
// the chain. Reset empties the list; slot contents are not cleared and are
// never observed past the held count.
// ----------------------------------------------------------------------------
module held_key_list
	import hkl_pkg::*;
#(
	parameter int LIST_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	localparam int CW = $clog2(LIST_DEPTH + 1);

	tok_t          tok [0:LIST_DEPTH];
	logic [6:0]    keys [0:LIST_DEPTH];
	logic [CW-1:0] total_q;
	logic [CW-1:0] total_nxt;
	fsm_t          fsm_q;
	fsm_t          fsm_nxt;
	logic          accept;
	logic          launch;
	logic          finish;
	logic          wr_en;
	rsp_t          rsp_nxt;
	rsp_t          rsp_q;
	logic          done_q;
	logic [31:0]   count_ext;
	logic [7:0]    code_byte;

	assign accept    = start && !busy;
	assign code_byte = req.scan_byte & CODE_MASK;
	assign launch    = accept && (req.cmd == CMD_READ ||
	                   (req.cmd == CMD_SCAN && req.scan_byte != ZERO_BYTE));
	assign finish    = tok[LIST_DEPTH].active;

	always_comb begin
		tok[0]        = '0;
		tok[0].active = launch;
		tok[0].code   = code_byte[6:0];
		tok[0].idx    = req.slot_index;
		if (req.cmd == CMD_READ) begin
			tok[0].op = OP_READ;
		end else if ((req.scan_byte & RELEASE_BIT) != ZERO_BYTE) begin
			tok[0].op = OP_RELEASE;
		end else begin
			tok[0].op = OP_PROBE;
		end
	end

	assign keys[LIST_DEPTH] = '0;

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		hkl_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1]),
			.total    (total_q),
			.next_key (keys[i+1]),
			.wr_en    (wr_en),
			.wr_idx   (total_q),
			.wr_key   (tok[LIST_DEPTH].code),
			.key      (keys[i])
		);
	end

	always_comb begin
		fsm_nxt = fsm_q;
		unique case (fsm_q)
			FSM_IDLE: if (launch) fsm_nxt = FSM_WALK;
			FSM_WALK: if (finish) fsm_nxt = FSM_IDLE;
			default:  fsm_nxt = FSM_IDLE;
		endcase
	end

	always_comb begin
		busy = (fsm_q == FSM_WALK);
	end

	always_comb begin
		rsp_nxt   = '0;
		total_nxt = total_q;
		wr_en     = 1'b0;
		if (finish) begin
			unique case (tok[LIST_DEPTH].op)
				OP_RELEASE: begin
					if (tok[LIST_DEPTH].found) begin
						rsp_nxt.status = ST_RELEASED;
						total_nxt      = total_q - CW'(1);
					end else begin
						rsp_nxt.status = ST_NOTFOUND;
					end
				end
				OP_PROBE: begin
					if (tok[LIST_DEPTH].found) begin
						rsp_nxt.status = ST_HELD;
					end else if (total_q == CW'(LIST_DEPTH)) begin
						rsp_nxt.status = ST_FULL;
					end else begin
						rsp_nxt.status = ST_ADDED;
						total_nxt      = total_q + CW'(1);
						wr_en          = 1'b1;
					end
				end
				default: begin
					rsp_nxt.status     = ST_READ;
					rsp_nxt.slot_valid = 32'(tok[LIST_DEPTH].idx) < 32'(total_q);
					rsp_nxt.slot_key   = rsp_nxt.slot_valid ?
					                     tok[LIST_DEPTH].rkey : 7'd0;
				end
			endcase
		end else if (accept && req.cmd == CMD_CLEAR) begin
			rsp_nxt.status = ST_CLEARED;
			total_nxt      = '0;
		end else begin
			rsp_nxt.status = ST_IGNORED;
		end
		count_ext          = 32'(total_nxt);
		rsp_nxt.held_count = count_ext[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= FSM_IDLE;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			fsm_q   <= fsm_nxt;
			total_q <= total_nxt;
			done_q  <= finish || (accept && !launch);
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_nxt;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire
